// ===== src/tlbpt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlbpt_pkg
// shared types and constants of the tlb / page table translator
// ----------------------------------------------------------------------------
package tlbpt_pkg;

    // item field widths
    localparam int ADDR_W      = 16;
    localparam int OFFSET_BITS = 8;
    localparam int PAGE_FIELD_W = ADDR_W - OFFSET_BITS;
    localparam int PAGE_SPACE  = 2 ** PAGE_FIELD_W;
    localparam int FRAME_W     = 8;
    localparam int COUNT_W     = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // defaults of the top level parameters
    localparam int DEF_TLB_ENTRIES = 16;
    localparam int DEF_PAGE_COUNT  = 256;
    localparam int DEF_FRAME_COUNT = 256;

    // control sequencer
    typedef enum logic [0:0] {
        ST_IDLE,
        ST_LOOKUP
    } state_t;

endpackage : tlbpt_pkg
`default_nettype wire

// ===== src/tlb_page_table_translator_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlb_page_table_translator_top
// address translation with a fifo-replaced tlb and demand paging
// ----------------------------------------------------------------------------
// usage
//   input channel: one 16-bit logical address per beat (page in 15:8, offset
//   in 7:0), handshake in_valid / in_stall.
//   output channel: one result beat per input beat, handshake out_valid /
//   out_stall: physical address, frame, hit / fault / out-of-frames flags and
//   saturating fault and miss counts.
// timing
//   an item is accepted only in the idle state; its page map entry is read
//   at accept, since the page map is a synchronous ram. the lookup state then
//   resolves, writes back and loads the result into the output register, and
//   no new item is taken until the lookup state is left.
// reset
//   tlb valid bits, page map valid bits, fifo pointer, free-frame counter and
//   both counts are cleared at once; no clearing pass, an item can be taken
//   in the first cycle after reset.
// stall
//   a finished result waits in the output register. the next item is still
//   accepted; its lookup cycle holds (re-reading the same map entry) until
//   the output register is free.
// frames are never released and always go to the lowest free one, so the
// used frames form a prefix and a counter gives the lowest free frame.
// ----------------------------------------------------------------------------
module tlb_page_table_translator_top #(
    parameter int TLB_ENTRIES = tlbpt_pkg::DEF_TLB_ENTRIES,
    parameter int PAGE_COUNT  = tlbpt_pkg::DEF_PAGE_COUNT,
    parameter int FRAME_COUNT = tlbpt_pkg::DEF_FRAME_COUNT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // input channel
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [tlbpt_pkg::ADDR_W-1:0]   vaddr,
    // output channel
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [tlbpt_pkg::ADDR_W-1:0]        paddr,
    output logic [tlbpt_pkg::FRAME_W-1:0]       frame_num,
    output logic                                tlb_hit,
    output logic                                page_fault,
    output logic                                out_of_frames,
    output logic [tlbpt_pkg::COUNT_W-1:0]       fault_count,
    output logic [tlbpt_pkg::COUNT_W-1:0]       miss_count
);
    import tlbpt_pkg::*;

    localparam int TLB_W  = $clog2(TLB_ENTRIES);
    localparam int PAGE_W = $clog2(PAGE_COUNT);
    localparam int FCNT_W = $clog2(FRAME_COUNT + 1);

    // page number reduced modulo the page count, folded at elaboration
    logic [PAGE_W-1:0] page_rom [PAGE_SPACE];
    for (genvar g = 0; g < PAGE_SPACE; g++) begin : g_page_rom
        assign page_rom[g] = PAGE_W'(g % PAGE_COUNT);
    end

    // sequencer
    state_t state_reg, state_next;

    // item held through the lookup cycle
    logic [PAGE_W-1:0]      page_reg;
    logic [OFFSET_BITS-1:0] offset_reg;

    // tlb, searched in parallel
    logic [PAGE_W-1:0]      tlb_tag_reg   [TLB_ENTRIES];
    logic [FRAME_W-1:0]     tlb_frame_reg [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0] tlb_valid_reg;
    logic [TLB_W-1:0]       fifo_ptr_reg, fifo_ptr_next;

    // page map: valid bits in flops, frame numbers in a synchronous ram
    logic [PAGE_COUNT-1:0]  map_valid_reg;
    logic [FRAME_W-1:0]     map_mem [PAGE_COUNT];
    logic [FRAME_W-1:0]     map_rd_data_reg;
    logic [PAGE_W-1:0]      map_rd_addr;
    logic                   map_we;

    // allocation and statistics
    logic [FCNT_W-1:0]      next_free_reg, next_free_next;
    logic [COUNT_W-1:0]     faults_reg, faults_next;
    logic [COUNT_W-1:0]     misses_reg, misses_next;

    // output register
    logic                   out_valid_reg;
    logic [ADDR_W-1:0]      phys_reg;
    logic [FRAME_W-1:0]     frame_reg;
    logic                   hit_reg;
    logic                   fault_reg;
    logic                   oof_reg;

    // lookup datapath
    logic                   accept;
    logic                   finish;
    logic [TLB_ENTRIES-1:0] tlb_match;
    logic                   hit;
    logic [FRAME_W-1:0]     tlb_frame_sel;
    logic                   mapped;
    logic                   none_free;
    logic                   fault;
    logic                   miss_ok;
    logic [FRAME_W-1:0]     frame;

    // ---------------------------------------------------------------- fsm
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall    = 1'b1;
        finish      = 1'b0;
        map_rd_addr = page_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                map_rd_addr = page_rom[vaddr[ADDR_W-1:OFFSET_BITS]];
            end
            ST_LOOKUP:
            begin
                finish = !out_valid_reg || !out_stall;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    assign accept = in_valid && !in_stall;

    // ------------------------------------------------------------- lookup
    always_comb
    begin
        tlb_frame_sel = '0;
        for (int i = 0; i < TLB_ENTRIES; i++)
        begin
            tlb_match[i] = tlb_valid_reg[i] && (tlb_tag_reg[i] == page_reg);
            // duplicate tags cannot arise, so an or of the matches is exact
            tlb_frame_sel = tlb_frame_sel | (tlb_match[i] ? tlb_frame_reg[i] : '0);
        end
        hit       = |tlb_match;
        mapped    = map_valid_reg[page_reg];
        none_free = !hit && !mapped && (next_free_reg == FCNT_W'(FRAME_COUNT));
        fault     = !hit && !mapped && !none_free;
        miss_ok   = !hit && !none_free;

        if (hit)
        begin
            frame = tlb_frame_sel;
        end
        else if (mapped)
        begin
            frame = map_rd_data_reg;
        end
        else
        begin
            frame = FRAME_W'(next_free_reg);
        end

        map_we = finish && fault;

        next_free_next = next_free_reg;
        faults_next    = faults_reg;
        if (fault)
        begin
            next_free_next = next_free_reg + FCNT_W'(1);
            faults_next    = (faults_reg == COUNT_MAX) ? faults_reg : faults_reg + COUNT_W'(1);
        end

        fifo_ptr_next = fifo_ptr_reg;
        misses_next   = misses_reg;
        if (miss_ok)
        begin
            fifo_ptr_next = (fifo_ptr_reg == TLB_W'(TLB_ENTRIES - 1)) ?
                            '0 : fifo_ptr_reg + TLB_W'(1);
            misses_next   = (misses_reg == COUNT_MAX) ? misses_reg : misses_reg + COUNT_W'(1);
        end
    end

    // ------------------------------------------------------ page map ram
    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[page_reg] <= frame;
        end
        map_rd_data_reg <= map_mem[map_rd_addr];
    end

    // ------------------------------------------------------ control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tlb_valid_reg <= '0;
            fifo_ptr_reg  <= '0;
            map_valid_reg <= '0;
            next_free_reg <= '0;
            faults_reg    <= '0;
            misses_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (finish)
            begin
                next_free_reg <= next_free_next;
                faults_reg    <= faults_next;
                fifo_ptr_reg  <= fifo_ptr_next;
                misses_reg    <= misses_next;
                if (fault)
                begin
                    map_valid_reg[page_reg] <= 1'b1;
                end
                if (miss_ok)
                begin
                    tlb_valid_reg[fifo_ptr_reg] <= 1'b1;
                end
            end
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------ payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            page_reg   <= page_rom[vaddr[ADDR_W-1:OFFSET_BITS]];
            offset_reg <= vaddr[OFFSET_BITS-1:0];
        end
        if (finish && miss_ok)
        begin
            tlb_tag_reg[fifo_ptr_reg]   <= page_reg;
            tlb_frame_reg[fifo_ptr_reg] <= frame;
        end
        if (finish)
        begin
            phys_reg  <= none_free ? '0 : {frame, offset_reg};
            frame_reg <= none_free ? '0 : frame;
            hit_reg   <= hit;
            fault_reg <= fault;
            oof_reg   <= none_free;
        end
    end

    assign out_valid     = out_valid_reg;
    assign paddr         = phys_reg;
    assign frame_num     = frame_reg;
    assign tlb_hit       = hit_reg;
    assign page_fault    = fault_reg;
    assign out_of_frames = oof_reg;
    assign fault_count   = faults_reg;
    assign miss_count    = misses_reg;

    // --------------------------------------------------------- assertions
    a_accept_starts_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == ST_LOOKUP)
        else $error("accepted beat did not start a lookup");

    a_oof_flags_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_of_frames |-> !tlb_hit && !page_fault && frame_num == '0)
        else $error("out-of-frames result carries hit, fault or frame");

    a_free_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        next_free_reg <= FCNT_W'(FRAME_COUNT))
        else $error("free-frame counter past frame count");

    a_faults_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> faults_reg >= $past(faults_reg) && misses_reg >= $past(misses_reg))
        else $error("fault or miss count went down");

endmodule : tlb_page_table_translator_top
`default_nettype wire

// ===== sim/tlb_page_table_translator_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlb_page_table_translator_top_tb
// self-checking bench: addresses in, translations checked against a
// behavioral tlb / page map / frame allocator kept alongside the block
// ----------------------------------------------------------------------------
module tlb_page_table_translator_top_tb;

    import tlbpt_pkg::*;

    localparam int TLB_SLOTS    = DEF_TLB_ENTRIES;
    localparam int PAGES        = DEF_PAGE_COUNT;
    localparam int FRAMES       = DEF_FRAME_COUNT;
    localparam int STALL_LIMIT  = 4000;   // cycles with no beat on either side
    localparam int RANDOM_BEATS = 480;    // per idling phase
    localparam int MISS_BEATS   = 60;     // rotating pages that always miss

    // one expected translation
    typedef struct packed {
        logic [ADDR_W-1:0]  phys;
        logic [FRAME_W-1:0] frame;
        logic               hit;
        logic               fault;
        logic               no_frame;
        logic [COUNT_W-1:0] faults;
        logic [COUNT_W-1:0] misses;
    } translation_t;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [ADDR_W-1:0]    vaddr = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [ADDR_W-1:0]    paddr;
    logic [FRAME_W-1:0]   frame_num;
    logic                 tlb_hit;
    logic                 page_fault;
    logic                 out_of_frames;
    logic [COUNT_W-1:0]   fault_count;
    logic [COUNT_W-1:0]   miss_count;

    // addresses waiting to be driven, translations waiting to come back
    logic [ADDR_W-1:0]    pending_addresses[$];
    translation_t         expected_translations[$];

    // behavioral copy of the translation state
    logic [FRAME_W-1:0]   slot_page [TLB_SLOTS];
    logic [FRAME_W-1:0]   slot_frame[TLB_SLOTS];
    logic                 slot_valid[TLB_SLOTS];
    logic [3:0]           replace_slot;
    logic [FRAME_W-1:0]   page_frame [PAGES];
    logic                 page_mapped[PAGES];
    logic                 frame_taken[FRAMES];
    logic [COUNT_W-1:0]   faults_so_far;
    logic [COUNT_W-1:0]   misses_so_far;

    // idling rates in percent, changed between phases
    int unsigned          sender_idle_pct   = 11;
    int unsigned          receiver_idle_pct = 74;

    int                   error_count = 0;
    int                   idle_cycles = 0;

    // run statistics
    int                   beats_checked = 0;
    int                   hits_seen     = 0;
    int                   faults_seen   = 0;
    int                   walks_seen    = 0;
    int                   no_frame_seen = 0;
    logic [COUNT_W-1:0]   top_miss_count = '0;

    tlb_page_table_translator_top u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .vaddr            (vaddr),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .paddr            (paddr),
        .frame_num        (frame_num),
        .tlb_hit          (tlb_hit),
        .page_fault       (page_fault),
        .out_of_frames    (out_of_frames),
        .fault_count      (fault_count),
        .miss_count       (miss_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // saturating increment of a running count
    function automatic logic [COUNT_W-1:0] count_up(input logic [COUNT_W-1:0] v);
        return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

    // translate one address and advance the behavioral state
    function automatic translation_t translate_address(input logic [ADDR_W-1:0] la);
        translation_t       r;
        logic [7:0]         page;
        logic [7:0]         offset;
        logic [FRAME_W-1:0] frame;
        logic               hit;
        logic               fault;
        logic               no_frame;
        logic               found;
        page     = 8'(int'(la[15:8]) % PAGES);
        offset   = la[7:0];
        frame    = '0;
        hit      = 1'b0;
        fault    = 1'b0;
        no_frame = 1'b0;
        found    = 1'b0;

        // lowest matching valid slot wins
        for (int s = 0; s < TLB_SLOTS; s++)
        begin
            if (!hit && slot_valid[s] && slot_page[s] == page)
            begin
                frame = slot_frame[s];
                hit   = 1'b1;
            end
        end

        if (!hit)
        begin
            if (page_mapped[page])
                frame = page_frame[page];
            else
            begin
                // demand paging: lowest free frame
                for (int f = 0; f < FRAMES; f++)
                begin
                    if (!found && !frame_taken[f])
                    begin
                        frame = FRAME_W'(f);
                        found = 1'b1;
                    end
                end
                if (!found)
                    no_frame = 1'b1;
                else
                begin
                    fault              = 1'b1;
                    frame_taken[frame] = 1'b1;
                    page_frame[page]   = frame;
                    page_mapped[page]  = 1'b1;
                    faults_so_far      = count_up(faults_so_far);
                end
            end
            if (!no_frame)
            begin
                slot_page[replace_slot]  = page;
                slot_frame[replace_slot] = frame;
                slot_valid[replace_slot] = 1'b1;
                replace_slot             = 4'((int'(replace_slot) + 1) % TLB_SLOTS);
                misses_so_far            = count_up(misses_so_far);
            end
        end

        r.phys     = no_frame ? '0 : {frame, offset};
        r.frame    = no_frame ? '0 : frame;
        r.hit      = hit;
        r.fault    = fault;
        r.no_frame = no_frame;
        r.faults   = faults_so_far;
        r.misses   = misses_so_far;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // driver: presents the head of the pending queue, holds it while stalled,
    // and runs the prediction at the edge where the beat is taken
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            vaddr    <= '0;
            // the whole translation state starts empty
            for (int s = 0; s < TLB_SLOTS; s++)
            begin
                slot_page[s]  = '0;
                slot_frame[s] = '0;
                slot_valid[s] = 1'b0;
            end
            for (int p = 0; p < PAGES; p++)
            begin
                page_frame[p]  = '0;
                page_mapped[p] = 1'b0;
            end
            for (int f = 0; f < FRAMES; f++)
                frame_taken[f] = 1'b0;
            replace_slot  = '0;
            faults_so_far = '0;
            misses_so_far = '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_translations.push_back(translate_address(vaddr));
                void'(pending_addresses.pop_front());
            end
            // a stalled beat stays put; otherwise offer the next one or idle
            if (!(in_valid && in_stall))
            begin
                if (pending_addresses.size() != 0 &&
                    $urandom_range(99) >= sender_idle_pct)
                begin
                    in_valid <= 1'b1;
                    vaddr    <= pending_addresses[0];
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: checks each result beat against the oldest expectation and
    // throttles the output side
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : monitor
        translation_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_translations.size() == 0)
                begin
                    $error("result beat with no translation outstanding");
                    error_count++;
                end
                else
                begin
                    want = expected_translations.pop_front();
                    check_field("paddr", want.phys, paddr);
                    check_field("frame_num", 16'(want.frame), 16'(frame_num));
                    check_field("tlb_hit", 16'(want.hit), 16'(tlb_hit));
                    check_field("page_fault", 16'(want.fault), 16'(page_fault));
                    check_field("out_of_frames", 16'(want.no_frame), 16'(out_of_frames));
                    check_field("fault_count", want.faults, fault_count);
                    check_field("miss_count", want.misses, miss_count);
                    beats_checked++;
                    if (want.hit)
                        hits_seen++;
                    else if (want.fault)
                        faults_seen++;
                    else if (want.no_frame)
                        no_frame_seen++;
                    else
                        walks_seen++;
                    top_miss_count = want.misses;
                end
            end
            out_stall <= ($urandom_range(99) < receiver_idle_pct);
        end
    end

    // watchdog: a run that stops moving is a failure
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // sender holds off until every outstanding translation is back
    task automatic wait_until_drained();
        while (pending_addresses.size() != 0 || expected_translations.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // stimulus: directed corners, three random phases with different idling,
    // then a short stream over rotating pages that never hits the tlb
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        logic [7:0] hot_page;
        logic [7:0] page;
        int unsigned pick;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: all-zero and all-one addresses, first hit on a page,
        // alternating bit patterns
        pending_addresses.push_back(16'h0000);   // fault, frame 0
        pending_addresses.push_back(16'h00FF);   // hit on the same page
        pending_addresses.push_back(16'hFFFF);   // top page faults into frame 1
        pending_addresses.push_back(16'hFF00);   // hit
        pending_addresses.push_back(16'hAA55);
        pending_addresses.push_back(16'h55AA);
        // seventeen fresh pages: fill the tlb and wrap the replacement pointer
        for (int p = 16'h10; p <= 16'h20; p++)
            pending_addresses.push_back({8'(p), 8'($urandom_range(255))});
        // page 0 was pushed out of the tlb but is still mapped: table walk
        pending_addresses.push_back(16'h0012);
        wait_until_drained();

        hot_page = 8'($urandom_range(255));
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_idle_pct   = 11;
                    receiver_idle_pct = 74;
                end
                1:
                begin
                    sender_idle_pct   = 74;
                    receiver_idle_pct = 11;
                end
                default:
                begin
                    sender_idle_pct   = 0;
                    receiver_idle_pct = 0;
                end
            endcase
            // mostly a small working set (hits), some neighbors (walks once
            // evicted), some anywhere (faults until every page is mapped)
            for (int n = 0; n < RANDOM_BEATS; n++)
            begin
                if ($urandom_range(49) == 0)
                    hot_page = 8'($urandom_range(255));
                pick = $urandom_range(99);
                if (pick < 55)
                    page = hot_page + 8'($urandom_range(11));
                else if (pick < 80)
                    page = hot_page + 8'($urandom_range(31));
                else
                    page = 8'($urandom_range(255));
                pending_addresses.push_back({page, 8'($urandom_range(255))});
            end
            // pause the sender until everything is back
            wait_until_drained();
        end

        // twenty pages in rotation always miss a sixteen-slot fifo tlb
        for (int n = 0; n < MISS_BEATS; n++)
            pending_addresses.push_back({8'(8'h40 + n % 20), 8'($urandom_range(255))});
        wait_until_drained();

        // let anything stray come out
        repeat (20) @(posedge clk);

        $display("checked %0d translations: %0d tlb hits, %0d page faults, %0d table walks,",
                 beats_checked, hits_seen, faults_seen, walks_seen);
        $display("%0d out-of-frame results; miss count reached %0d under three idling mixes",
                 no_frame_seen, top_miss_count);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
